/* hw/rtl/assert_macros.svh */
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define CHK_SAME(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");

// next-cycle implication, disabled in reset
`define CHK_NEXT(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");

`endif

/* hw/rtl/aac_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aac_pkg
// Types and codes shared by the address cache controller and datapath.
// ----------------------------------------------------------------------------
package aac_pkg;

  localparam int AGE_W = 5;
  localparam int CNT_W = 8;
  localparam int MAC_W = 48;

  // item kinds
  localparam logic [1:0] KIND_RESOLVE = 2'd0;
  localparam logic [1:0] KIND_LEARN   = 2'd1;
  localparam logic [1:0] KIND_PROBE   = 2'd2;
  localparam logic [1:0] KIND_TICK    = 2'd3;

  // result status codes
  localparam logic [2:0] ST_RESOLVED  = 3'd0;
  localparam logic [2:0] ST_PENDING   = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_LEARNED   = 3'd3;
  localparam logic [2:0] ST_FREED     = 3'd4;
  localparam logic [2:0] ST_NOCHANGE  = 3'd5;
  localparam logic [2:0] ST_TICK_DONE = 3'd6;

  // configuration register indexes
  localparam logic REG_COMPLETE_KILL   = 1'b0;
  localparam logic REG_INCOMPLETE_KILL = 1'b1;

  localparam logic [AGE_W-1:0] COMPLETE_KILL_RST   = 5'd20;
  localparam logic [AGE_W-1:0] INCOMPLETE_KILL_RST = 5'd3;

  typedef struct packed {
    logic [1:0]       kind;
    logic [15:0]      net;
    logic [7:0]       node;
    logic [MAC_W-1:0] mac;
    logic             to_me;
  } req_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [MAC_W-1:0] mac_out;
    logic             send_request;
    logic             dropped_hold;
    logic             release_hold;
    logic [CNT_W-1:0] expired_count;
  } result_t;

  typedef struct packed {
    logic             complete;
    logic             holding;
    logic [15:0]      net;
    logic [7:0]       node;
    logic [AGE_W-1:0] age;
    logic [MAC_W-1:0] mac;
  } entry_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic modr;
    logic rd;
    logic exec;
  } ctl_cmd_t;

  typedef struct packed {
    logic is_tick;
    logic last_bucket;
  } ctl_sts_t;

endpackage

/* hw/rtl/aac_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aac_ctrl
// Sequencer: hash, bucket read, bucket update, and the aging walk.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module aac_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [1:0]        start_kind,
  output logic              busy,
  output aac_pkg::ctl_cmd_t cmd,
  input  aac_pkg::ctl_sts_t sts
);

  typedef enum logic [2:0] {S_IDLE, S_MUL, S_MOD, S_RD, S_EXEC} state_t;

  state_t state;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            state <= (start_kind == aac_pkg::KIND_TICK) ? S_RD : S_MUL;
          end
        end
        S_MUL:  state <= S_MOD;
        S_MOD:  state <= S_RD;
        S_RD:   state <= S_EXEC;
        S_EXEC: state <= (sts.is_tick && !sts.last_bucket) ? S_RD : S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // command decode
  assign busy      = (state != S_IDLE);
  assign cmd.load  = start && (state == S_IDLE);
  assign cmd.mul   = (state == S_MUL);
  assign cmd.modr  = (state == S_MOD);
  assign cmd.rd    = (state == S_RD);
  assign cmd.exec  = (state == S_EXEC);

  `CHK_NEXT(a_accept_busy, clk, rst, cmd.load, busy)
  `CHK_NEXT(a_read_then_exec, clk, rst, cmd.rd, state == S_EXEC)
  `CHK_NEXT(a_lookup_one_row, clk, rst, cmd.exec && !sts.is_tick, state == S_IDLE)

endmodule

/* hw/rtl/aac_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aac_datapath
// Bucket hash, bucket row memory, way valid bits, row update and result.
// ----------------------------------------------------------------------------
module aac_datapath #(
  parameter int WAYS    = 9,
  parameter int BUCKETS = 19
) (
  input  logic              clk,
  input  logic              rst,
  input  aac_pkg::req_t     request,
  input  logic              cfg_valid,
  input  logic              cfg_index,
  input  logic [4:0]        cfg_data,
  input  aac_pkg::ctl_cmd_t cmd,
  output aac_pkg::ctl_sts_t sts,
  output aac_pkg::result_t  result,
  output logic              result_valid
);

  localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int BKT_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int KEY_W = 24;
  localparam int SHIFT = 32;
  localparam longint RECIP = (64'd1 << SHIFT) / BUCKETS;
  localparam logic [SHIFT:0] RECIP_V = RECIP[SHIFT:0];
  localparam logic [BKT_W:0] BKT_N = BUCKETS[BKT_W:0];
  localparam logic [BKT_W-1:0] BKT_LAST = BKT_W'(BUCKETS - 1);

  typedef aac_pkg::entry_t [WAYS-1:0] row_t;

  aac_pkg::req_t req_q;
  logic [aac_pkg::AGE_W-1:0] complete_kill;
  logic [aac_pkg::AGE_W-1:0] incomplete_kill;
  logic [KEY_W+SHIFT:0] prod;
  logic [BKT_W-1:0] bucket;
  row_t mem [BUCKETS];
  row_t mem_q;
  logic [WAYS-1:0] used [BUCKETS];
  logic [aac_pkg::CNT_W-1:0] exp_cnt;
  logic drop_acc;

  logic [KEY_W-1:0] key;
  logic [KEY_W-1:0] quot;
  logic [31:0] rem_wide;
  logic [BKT_W:0] rem0;
  logic [WAYS-1:0] used_row;
  logic is_tick;

  logic hit_found, free_found;
  logic [WAY_W-1:0] hit_w, free_w, old_w, pick;
  logic [aac_pkg::AGE_W-1:0] old_age, aged, lim;
  logic alloc_drop;
  row_t new_row;
  logic [WAYS-1:0] new_used;
  logic [aac_pkg::CNT_W-1:0] kill_cnt;
  logic tick_drop;
  aac_pkg::result_t res;

  assign key      = {req_q.net, req_q.node};
  assign quot     = prod[SHIFT+KEY_W-1:SHIFT];
  assign rem_wide = 32'(key) - 32'(quot) * 32'(BUCKETS);
  assign rem0     = rem_wide[BKT_W:0];
  assign used_row = used[bucket];
  assign is_tick  = (req_q.kind == aac_pkg::KIND_TICK);

  assign sts.is_tick     = is_tick;
  assign sts.last_bucket = (bucket == BKT_LAST);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      complete_kill   <= aac_pkg::COMPLETE_KILL_RST;
      incomplete_kill <= aac_pkg::INCOMPLETE_KILL_RST;
    end else if (cfg_valid) begin
      if (cfg_index == aac_pkg::REG_COMPLETE_KILL) begin
        complete_kill <= cfg_data;
      end else begin
        incomplete_kill <= cfg_data;
      end
    end
  end

  // item capture, hash by reciprocal multiply, bucket counter, tick totals
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q   <= request;
      bucket  <= '0;
      exp_cnt <= '0;
      drop_acc <= 1'b0;
    end
    if (cmd.mul) begin
      prod <= (KEY_W+SHIFT+1)'(key) * (KEY_W+SHIFT+1)'(RECIP_V);
    end
    if (cmd.modr) begin
      bucket <= (rem0 >= BKT_N) ? BKT_W'(rem0 - BKT_N) : rem0[BKT_W-1:0];
    end
    if (cmd.exec && is_tick) begin
      exp_cnt  <= exp_cnt + kill_cnt;
      drop_acc <= drop_acc | tick_drop;
      if (!sts.last_bucket) begin
        bucket <= bucket + 1'b1;
      end
    end
  end

  // bucket row memory
  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      mem_q <= mem[bucket];
    end
    if (cmd.exec) begin
      mem[bucket] <= new_row;
    end
  end

  // way valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int b = 0; b < BUCKETS; b++) begin
        used[b] <= '0;
      end
    end else if (cmd.exec) begin
      used[bucket] <= new_used;
    end
  end

  // way search: first match, first free, first oldest
  always_comb begin
    hit_found  = 1'b0;
    hit_w      = '0;
    free_found = 1'b0;
    free_w     = '0;
    old_w      = '0;
    old_age    = mem_q[0].age;
    for (int w = 0; w < WAYS; w++) begin
      if (used_row[w] && mem_q[w].net == req_q.net && mem_q[w].node == req_q.node
          && !hit_found) begin
        hit_found = 1'b1;
        hit_w     = WAY_W'(w);
      end
      if (!used_row[w] && !free_found) begin
        free_found = 1'b1;
        free_w     = WAY_W'(w);
      end
      if (mem_q[w].age > old_age) begin
        old_age = mem_q[w].age;
        old_w   = WAY_W'(w);
      end
    end
    pick       = free_found ? free_w : old_w;
    alloc_drop = !free_found && used_row[pick] && mem_q[pick].holding;
  end

  // row update and result
  always_comb begin
    new_row   = mem_q;
    new_used  = used_row;
    kill_cnt  = '0;
    tick_drop = 1'b0;
    aged      = '0;
    lim       = '0;
    res       = '0;
    res.status = aac_pkg::ST_NOCHANGE;
    case (req_q.kind)
      aac_pkg::KIND_RESOLVE: begin
        if (hit_found) begin
          new_row[hit_w].age = '0;
          if (mem_q[hit_w].complete) begin
            res.status  = aac_pkg::ST_RESOLVED;
            res.mac_out = mem_q[hit_w].mac;
          end else begin
            res.dropped_hold = mem_q[hit_w].holding;
            new_row[hit_w].holding = 1'b1;
            res.send_request = 1'b1;
            res.status = aac_pkg::ST_PENDING;
          end
        end else begin
          new_used[pick]         = 1'b1;
          new_row[pick].complete = 1'b0;
          new_row[pick].holding  = 1'b1;
          new_row[pick].age      = '0;
          new_row[pick].net      = req_q.net;
          new_row[pick].node     = req_q.node;
          res.dropped_hold = alloc_drop;
          res.send_request = 1'b1;
          res.status = aac_pkg::ST_PENDING;
        end
      end
      aac_pkg::KIND_LEARN: begin
        if (hit_found) begin
          new_row[hit_w].mac      = req_q.mac;
          new_row[hit_w].complete = 1'b1;
          new_row[hit_w].holding  = 1'b0;
          res.release_hold = mem_q[hit_w].holding;
          res.status = aac_pkg::ST_LEARNED;
        end else if (req_q.to_me) begin
          new_used[pick]         = 1'b1;
          new_row[pick].complete = 1'b1;
          new_row[pick].holding  = 1'b0;
          new_row[pick].age      = '0;
          new_row[pick].net      = req_q.net;
          new_row[pick].node     = req_q.node;
          new_row[pick].mac      = req_q.mac;
          res.dropped_hold = alloc_drop;
          res.status = aac_pkg::ST_LEARNED;
        end
      end
      aac_pkg::KIND_PROBE: begin
        if (hit_found) begin
          new_used[hit_w]  = 1'b0;
          res.dropped_hold = mem_q[hit_w].holding;
          res.status = aac_pkg::ST_FREED;
        end
      end
      aac_pkg::KIND_TICK: begin
        // age every used way of this bucket
        for (int w = 0; w < WAYS; w++) begin
          if (used_row[w]) begin
            aged = mem_q[w].age + 1'b1;
            lim  = mem_q[w].complete ? complete_kill : incomplete_kill;
            if (aged >= lim || aged == '0) begin
              new_used[w] = 1'b0;
              kill_cnt    = kill_cnt + 1'b1;
              tick_drop   = tick_drop | mem_q[w].holding;
            end else begin
              new_row[w].age = aged;
            end
          end
        end
        res.status        = aac_pkg::ST_TICK_DONE;
        res.dropped_hold  = drop_acc | tick_drop;
        res.expired_count = exp_cnt + kill_cnt;
      end
      default: begin
        res.status = aac_pkg::ST_NOCHANGE;
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.exec && (!is_tick || sts.last_bucket);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      result <= res;
    end
  end

endmodule

/* hw/rtl/aarp_address_cache.sv */
`timescale 1ns / 1ps
// resolve, learn and probe items go from start to the result strobe through a reciprocal hash
// (multiply, then modulo), one bucket row read, one row update and one output register
// an aging tick walks every bucket row in turn, with a row read and a row update for each
// busy is high while an item is in work; the next start is taken in the strobe cycle
// reset clears the way valid bits and loads the kill limits, no clearing pass
// results are shown for one cycle and cannot be stalled
// ----------------------------------------------------------------------------
// aarp_address_cache
// Hashed set-associative protocol to hardware address cache with aging.
// ----------------------------------------------------------------------------
module aarp_address_cache #(
  parameter int WAYS    = 9,
  parameter int BUCKETS = 19
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  aac_pkg::req_t    request,
  output aac_pkg::result_t result,
  output logic             result_valid,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic             cfg_index,
  input  logic [4:0]       cfg_data
);

  aac_pkg::ctl_cmd_t cmd;
  aac_pkg::ctl_sts_t sts;

  assign cfg_ready = 1'b1;

  // sequencer
  aac_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .start_kind (request.kind),
    .busy       (busy),
    .cmd        (cmd),
    .sts        (sts)
  );

  // storage and row logic
  aac_datapath #(
    .WAYS    (WAYS),
    .BUCKETS (BUCKETS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .request      (request),
    .cfg_valid    (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .sts          (sts),
    .result       (result),
    .result_valid (result_valid)
  );

endmodule

/* tb/aarp_address_cache_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aarp_address_cache_tb
// Drives resolve, learn, probe and aging items into the address cache,
// predicts every result from a private copy of the table and checks each
// strobed result in order. Kill limits are changed between idle phases.
// ----------------------------------------------------------------------------
module aarp_address_cache_tb;

  localparam int WAYS    = 9;
  localparam int BUCKETS = 19;
  localparam int SLOTS   = WAYS * BUCKETS;
  localparam int SETTLE  = 2 * BUCKETS + 12;
  localparam int STALL_LIMIT = 4000;

  // cache model and expected results
  class cache_scoreboard;
    logic [4:0]  kill_done;
    logic [4:0]  kill_wait;
    bit          used [SLOTS];
    bit          done [SLOTS];
    bit          hold [SLOTS];
    logic [15:0] e_net [SLOTS];
    logic [7:0]  e_node [SLOTS];
    logic [47:0] e_mac [SLOTS];
    logic [4:0]  e_age [SLOTS];
    aac_pkg::result_t pending_results [$];
    int          errors;

    function new();
      kill_done = aac_pkg::COMPLETE_KILL_RST;
      kill_wait = aac_pkg::INCOMPLETE_KILL_RST;
      errors = 0;
      for (int i = 0; i < SLOTS; i++) begin
        used[i] = 0; done[i] = 0; hold[i] = 0;
        e_net[i] = '0; e_node[i] = '0; e_mac[i] = '0; e_age[i] = '0;
      end
    endfunction

    function void set_limit(logic idx, logic [4:0] val);
      if (idx == aac_pkg::REG_COMPLETE_KILL) kill_done = val;
      else kill_wait = val;
    endfunction

    function int base_of(logic [15:0] net, logic [7:0] node);
      logic [31:0] key;
      key = ({16'b0, net} << 8) + node;
      return int'(key % BUCKETS) * WAYS;
    endfunction

    function int lookup(logic [15:0] net, logic [7:0] node);
      int b;
      b = base_of(net, node);
      for (int w = 0; w < WAYS; w++)
        if (used[b+w] && e_net[b+w] == net && e_node[b+w] == node) return b + w;
      return -1;
    endfunction

    function bit drop_slot(int i);
      bit h;
      h = hold[i];
      used[i] = 0; done[i] = 0; hold[i] = 0;
      e_age[i] = '0; e_net[i] = '0; e_node[i] = '0;
      return h;
    endfunction

    // free way first, else the oldest (first on a tie)
    function int claim(logic [15:0] net, logic [7:0] node, output bit lost);
      int b, pick, oldest;
      b = base_of(net, node);
      pick = b;
      oldest = -1;
      lost = 0;
      for (int w = 0; w < WAYS; w++) begin
        if (!used[b+w]) begin
          pick = b + w;
          oldest = -2;
          break;
        end
        if (int'(e_age[b+w]) > oldest) begin
          oldest = int'(e_age[b+w]);
          pick = b + w;
        end
      end
      if (oldest != -2) lost = drop_slot(pick);
      used[pick] = 1; done[pick] = 0; hold[pick] = 0;
      e_age[pick] = '0; e_net[pick] = net; e_node[pick] = node;
      return pick;
    endfunction

    // accepted item: update table and queue its result
    function void note(aac_pkg::req_t r);
      aac_pkg::result_t res;
      int i;
      bit d;
      logic [4:0] lim;
      res = '0;
      res.status = aac_pkg::ST_NOCHANGE;
      case (r.kind)
        aac_pkg::KIND_RESOLVE: begin
          i = lookup(r.net, r.node);
          if (i < 0) begin
            i = claim(r.net, r.node, d);
            res.dropped_hold = d;
            hold[i] = 1;
            res.send_request = 1;
            res.status = aac_pkg::ST_PENDING;
          end else begin
            e_age[i] = '0;
            if (done[i]) begin
              res.mac_out = e_mac[i];
              res.status = aac_pkg::ST_RESOLVED;
            end else begin
              res.dropped_hold = hold[i];
              hold[i] = 1;
              res.send_request = 1;
              res.status = aac_pkg::ST_PENDING;
            end
          end
        end
        aac_pkg::KIND_LEARN: begin
          i = lookup(r.net, r.node);
          if (i >= 0) begin
            e_mac[i] = r.mac;
            done[i] = 1;
            if (hold[i]) begin
              hold[i] = 0;
              res.release_hold = 1;
            end
            res.status = aac_pkg::ST_LEARNED;
          end else if (r.to_me) begin
            i = claim(r.net, r.node, d);
            res.dropped_hold = d;
            e_mac[i] = r.mac;
            done[i] = 1;
            res.status = aac_pkg::ST_LEARNED;
          end
        end
        aac_pkg::KIND_PROBE: begin
          i = lookup(r.net, r.node);
          if (i >= 0) begin
            res.dropped_hold = drop_slot(i);
            res.status = aac_pkg::ST_FREED;
          end
        end
        default: begin
          for (int k = 0; k < SLOTS; k++) begin
            if (!used[k]) continue;
            e_age[k] = e_age[k] + 5'd1;
            lim = done[k] ? kill_done : kill_wait;
            if (e_age[k] >= lim || e_age[k] == 0) begin
              if (drop_slot(k)) res.dropped_hold = 1;
              res.expired_count = res.expired_count + 8'd1;
            end
          end
          res.status = aac_pkg::ST_TICK_DONE;
        end
      endcase
      pending_results.push_back(res);
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %0h want %0h", what, got, want);
      errors++;
    endtask

    task check(aac_pkg::result_t got);
      aac_pkg::result_t want;
      if (pending_results.size() == 0) begin
        report("unexpected result", got.status, 0);
        return;
      end
      want = pending_results.pop_front();
      if (got.status !== want.status) report("status", got.status, want.status);
      if (got.mac_out !== want.mac_out) report("mac_out", got.mac_out, want.mac_out);
      if (got.send_request !== want.send_request)
        report("send_request", got.send_request, want.send_request);
      if (got.dropped_hold !== want.dropped_hold)
        report("dropped_hold", got.dropped_hold, want.dropped_hold);
      if (got.release_hold !== want.release_hold)
        report("release_hold", got.release_hold, want.release_hold);
      if (got.expired_count !== want.expired_count)
        report("expired_count", got.expired_count, want.expired_count);
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  aac_pkg::req_t    request;
  aac_pkg::result_t result;
  logic        result_valid;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [4:0]  cfg_data;

  cache_scoreboard sb;
  int          quiet_cycles;
  bit          moved;
  bit          steady;

  aarp_address_cache #(.WAYS(WAYS), .BUCKETS(BUCKETS)) u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .request(request),
    .result(result), .result_valid(result_valid), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // result capture
  always @(posedge clk) begin
    if (!rst && result_valid) begin
      sb.check(result);
      moved = 1;
    end
  end

  // watchdog on cycles with no progress
  always @(posedge clk) begin
    if (moved || rst) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    moved = 0;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("aarp_address_cache_tb: errors");
      $finish;
    end
  end

  // gap length: mostly none or short, a few long
  function int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task idle_for(int n);
    if (n > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task send_item(aac_pkg::req_t r);
    @(negedge clk);
    start <= 1'b1;
    request <= r;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    sb.note(r);
    moved = 1;
    idle_for(pick_gap());
  endtask

  // wait until every result is in, then let the block settle
  task drain();
    @(negedge clk);
    start <= 1'b0;
    while (sb.pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task write_limit(logic idx, logic [4:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    sb.set_limit(idx, val);
    moved = 1;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function aac_pkg::req_t make_req(logic [1:0] k, logic [15:0] net, logic [7:0] node,
                                   logic [47:0] mac, logic me);
    aac_pkg::req_t r;
    r.kind = k; r.net = net; r.node = node; r.mac = mac; r.to_me = me;
    return r;
  endfunction

  // random item: mostly a small address pool so hits, fills and evictions occur
  function aac_pkg::req_t random_req();
    int r;
    logic [1:0] k;
    logic [15:0] net;
    logic [7:0] node;
    r = $urandom_range(0, 99);
    if (r < 42) k = aac_pkg::KIND_RESOLVE;
    else if (r < 77) k = aac_pkg::KIND_LEARN;
    else if (r < 91) k = aac_pkg::KIND_PROBE;
    else k = aac_pkg::KIND_TICK;
    r = $urandom_range(0, 99);
    if (r < 50) begin
      net = 16'($urandom_range(0, 1));
      node = 8'($urandom_range(0, 40));
    end else if (r < 85) begin
      net = 16'($urandom_range(0, 3)) | 16'hfff0;
      node = 8'($urandom);
    end else begin
      net = 16'($urandom);
      node = 8'($urandom);
    end
    return make_req(k, net, node, {16'($urandom), 32'($urandom)}, 1'($urandom));
  endfunction

  task run_random(int count);
    for (int n = 0; n < count; n++) begin
      if (n % 100 == 0) steady = ($urandom_range(0, 3) == 0);
      send_item(random_req());
    end
    steady = 0;
  endtask

  // stimulus
  initial begin
    sb = new();
    rst = 1'b1;
    start = 1'b0;
    request = '0;
    cfg_valid = 1'b0;
    cfg_index = aac_pkg::REG_COMPLETE_KILL;
    cfg_data = '0;
    quiet_cycles = 0;
    moved = 0;
    steady = 0;
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // directed: miss, repeat, completion, hit, learn paths, probe, extremes
    send_item(make_req(aac_pkg::KIND_RESOLVE, 16'h0001, 8'h02, '0, 1'b0));
    send_item(make_req(aac_pkg::KIND_RESOLVE, 16'h0001, 8'h02, '0, 1'b0));
    send_item(make_req(aac_pkg::KIND_LEARN, 16'h0001, 8'h02, 48'h0123456789ab, 1'b0));
    send_item(make_req(aac_pkg::KIND_RESOLVE, 16'h0001, 8'h02, '0, 1'b0));
    send_item(make_req(aac_pkg::KIND_LEARN, 16'h0007, 8'h07, 48'h111111111111, 1'b0));
    send_item(make_req(aac_pkg::KIND_LEARN, 16'hffff, 8'hff, 48'hffffffffffff, 1'b1));
    send_item(make_req(aac_pkg::KIND_RESOLVE, 16'hffff, 8'hff, 48'hffffffffffff, 1'b1));
    send_item(make_req(aac_pkg::KIND_PROBE, 16'h0001, 8'h02, '0, 1'b0));
    send_item(make_req(aac_pkg::KIND_PROBE, 16'h0001, 8'h02, '0, 1'b0));
    send_item(make_req(aac_pkg::KIND_RESOLVE, 16'h0000, 8'h00, '0, 1'b0));
    // overfill one bucket to force eviction of a held frame
    for (int n = 1; n <= 10; n++)
      send_item(make_req(aac_pkg::KIND_RESOLVE, 16'h0000, 8'(n * BUCKETS), '0, 1'b0));
    send_item(make_req(aac_pkg::KIND_TICK, '0, '0, '0, 1'b0));
    send_item(make_req(aac_pkg::KIND_TICK, '0, '0, '0, 1'b0));
    send_item(make_req(aac_pkg::KIND_TICK, '0, '0, '0, 1'b0));
    run_random(500);

    // shortest limits, including zero
    drain();
    write_limit(aac_pkg::REG_COMPLETE_KILL, 5'd1);
    write_limit(aac_pkg::REG_INCOMPLETE_KILL, 5'd0);
    run_random(300);

    // longest limits, ages expire before they can wrap
    drain();
    write_limit(aac_pkg::REG_COMPLETE_KILL, 5'd31);
    write_limit(aac_pkg::REG_INCOMPLETE_KILL, 5'd31);
    run_random(450);

    drain();
    write_limit(aac_pkg::REG_COMPLETE_KILL, 5'd0);
    write_limit(aac_pkg::REG_INCOMPLETE_KILL, 5'd1);
    run_random(150);

    drain();
    write_limit(aac_pkg::REG_COMPLETE_KILL, 5'($urandom_range(2, 30)));
    write_limit(aac_pkg::REG_INCOMPLETE_KILL, 5'($urandom_range(2, 30)));
    run_random(430);

    drain();
    if (sb.errors == 0 && sb.pending_results.size() == 0)
      $display("aarp_address_cache_tb: clean");
    else
      $display("aarp_address_cache_tb: errors");
    $finish;
  end

endmodule
